[src/cra_pkg.sv]
// Shared types and constants of the compacting region allocator.
// Used by both interfaces and by every module of the block but cra_ram; depends on nothing.

package cra_pkg;

  // fixed field widths of the item channels
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned REQ_W  = 5;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned OFF_W  = 4;
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned USED_W = 5;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_UNITE  = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_ROOM   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD_SIZE  = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SWEEP,
    S_APPEND,
    S_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic decide;
    logic sweep;
    logic sweep_end;
    logic append;
    logic load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic ok;
    logic compact;
    logic append;
    logic out_busy;
  } stat_t;

endpackage

[src/cra_req_if.sv]
// Request channel of the compacting region allocator.
// Depends on cra_pkg for the field widths.

interface cra_req_if;
  logic                        valid;
  logic                        ready;
  logic [cra_pkg::FUNC_W-1:0]  func;
  logic [cra_pkg::REQ_W-1:0]   req_size;
  logic [cra_pkg::ID_W-1:0]    first_id;
  logic [cra_pkg::ID_W-1:0]    second_id;

  modport source (output valid, func, req_size, first_id, second_id, input ready);
  modport sink   (input valid, func, req_size, first_id, second_id, output ready);
endinterface

[src/cra_rsp_if.sv]
// Response channel of the compacting region allocator.
// Depends on cra_pkg for the field widths.

interface cra_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [cra_pkg::ID_W-1:0]    region_id;
  logic [cra_pkg::OFF_W-1:0]   region_offset;
  logic [cra_pkg::SIZE_W-1:0]  region_size;
  logic [cra_pkg::USED_W-1:0]  used_units;

  modport source (output valid, status, region_id, region_offset, region_size, used_units,
                  input ready);
  modport sink   (input valid, status, region_id, region_offset, region_size, used_units,
                  output ready);
endinterface

[src/cra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.

module cra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/cra_ctrl.sv]
// Controller of the compacting region allocator: sequences scan, decision,
// compaction sweep, append and result hand-off. Depends on cra_pkg.

module cra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cra_pkg::stat_t  stat_i,
  output cra_pkg::cmd_t   cmd_o
);

  cra_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cra_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cra_pkg::S_IDLE: begin
        if (in_valid_i) state_d = cra_pkg::S_SCAN;
      end
      cra_pkg::S_SCAN: begin
        if (stat_i.sweep_done) state_d = cra_pkg::S_DECIDE;
      end
      cra_pkg::S_DECIDE: begin
        if (!stat_i.ok) begin
          state_d = cra_pkg::S_DONE;
        end else if (stat_i.compact) begin
          state_d = cra_pkg::S_SWEEP;
        end else if (stat_i.append) begin
          state_d = cra_pkg::S_APPEND;
        end else begin
          state_d = cra_pkg::S_DONE;
        end
      end
      cra_pkg::S_SWEEP: begin
        if (stat_i.sweep_done) begin
          state_d = stat_i.append ? cra_pkg::S_APPEND : cra_pkg::S_DONE;
        end
      end
      cra_pkg::S_APPEND: begin
        state_d = cra_pkg::S_DONE;
      end
      cra_pkg::S_DONE: begin
        if (!stat_i.out_busy) state_d = cra_pkg::S_IDLE;
      end
      default: begin
        state_d = cra_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      cra_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      cra_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      cra_pkg::S_DECIDE: begin
        cmd_o.decide = 1'b1;
      end
      cra_pkg::S_SWEEP: begin
        cmd_o.sweep     = 1'b1;
        cmd_o.sweep_end = stat_i.sweep_done && !stat_i.append;
      end
      cra_pkg::S_APPEND: begin
        cmd_o.append = 1'b1;
      end
      cra_pkg::S_DONE: begin
        cmd_o.load_out = !stat_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[src/cra_datapath.sv]
// Datapath of the compacting region allocator: region list RAMs, scan and
// compaction pointers, decision logic and the result register.
// Depends on cra_pkg and cra_ram.

module cra_datapath #(
  parameter int unsigned CAPACITY_UNITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cra_pkg::cmd_t               cmd_i,
  output cra_pkg::stat_t              stat_o,
  input  logic [cra_pkg::FUNC_W-1:0]  func_i,
  input  logic [cra_pkg::REQ_W-1:0]   req_size_i,
  input  logic [cra_pkg::ID_W-1:0]    first_id_i,
  input  logic [cra_pkg::ID_W-1:0]    second_id_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [1:0]                  status_o,
  output logic [cra_pkg::ID_W-1:0]    region_id_o,
  output logic [cra_pkg::OFF_W-1:0]   region_offset_o,
  output logic [cra_pkg::SIZE_W-1:0]  region_size_o,
  output logic [cra_pkg::USED_W-1:0]  used_units_o
);

  localparam int unsigned UW  = $clog2(CAPACITY_UNITS + 1);
  localparam int unsigned IW  = $clog2(CAPACITY_UNITS);
  localparam int unsigned CW  = ((UW > cra_pkg::REQ_W) ? UW : cra_pkg::REQ_W) + 1;
  localparam int unsigned IDW = cra_pkg::ID_W;

  // latched item
  cra_pkg::func_e             func_q;
  logic [cra_pkg::REQ_W-1:0]  req_q;
  logic [IDW-1:0]             id1_q, id2_q;

  // allocator state
  logic [UW-1:0]  count_q, total_q;
  logic [IDW-1:0] fresh_q;

  // sweep pointers
  logic [UW-1:0]  rd_ptr_q, wr_ptr_q, acc_q;
  logic           rd_vld_q;
  logic [IW-1:0]  rd_idx_q;

  // scan findings
  logic           hit1_q, hit2_q;
  logic [IW-1:0]  pos1_q, pos2_q;
  logic [UW-1:0]  off1_q, size1_q, size2_q;
  logic [UW-1:0]  app_size_q;

  // pending result
  cra_pkg::status_e res_status_q, res_status_d;
  logic [IDW-1:0]   res_id_q, res_id_d;
  logic [UW-1:0]    res_off_q, res_size_q, res_used_q;
  logic [UW-1:0]    res_off_d, res_size_d, res_used_d;

  // output register
  logic                        out_vld_q;
  logic [1:0]                  out_status_q;
  logic [IDW-1:0]              out_id_q;
  logic [cra_pkg::OFF_W-1:0]   out_off_q;
  logic [cra_pkg::SIZE_W-1:0]  out_size_q;
  logic [cra_pkg::USED_W-1:0]  out_used_q;

  // ram ports
  logic           we;
  logic [IW-1:0]  waddr;
  logic [IDW-1:0] wdata_id, rdata_id;
  logic [UW-1:0]  wdata_size, rdata_size;
  logic           rd_issue;
  logic           keep;

  // decision
  cra_pkg::status_e dec_status;
  logic             dec_compact, dec_append;
  logic [UW-1:0]    combined, lo_pos;
  logic [CW-1:0]    req_w, room_w;

  cra_ram #(.WIDTH(IDW), .DEPTH(CAPACITY_UNITS)) u_ids (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata_id),
    .raddr_i (rd_ptr_q[IW-1:0]),
    .rdata_o (rdata_id)
  );

  cra_ram #(.WIDTH(UW), .DEPTH(CAPACITY_UNITS)) u_sizes (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata_size),
    .raddr_i (rd_ptr_q[IW-1:0]),
    .rdata_o (rdata_size)
  );

  // read issue during scan and sweep
  assign rd_issue = (cmd_i.scan || cmd_i.sweep) && (rd_ptr_q < count_q);

  // entries that survive compaction
  assign keep = (rd_idx_q != pos1_q) &&
                !((func_q == cra_pkg::FUNC_UNITE) && (rd_idx_q == pos2_q));

  // write port: sweep copies down, append writes the new region
  always_comb begin
    we         = 1'b0;
    waddr      = wr_ptr_q[IW-1:0];
    wdata_id   = rdata_id;
    wdata_size = rdata_size;
    if (cmd_i.append) begin
      we         = 1'b1;
      wdata_id   = fresh_q;
      wdata_size = app_size_q;
    end else if (cmd_i.sweep && rd_vld_q && keep) begin
      we = 1'b1;
    end
  end

  // decision on the scanned list
  assign req_w    = CW'(req_q);
  assign room_w   = CW'(CAPACITY_UNITS) - CW'(total_q);
  assign combined = size1_q + size2_q;
  assign lo_pos   = ((func_q == cra_pkg::FUNC_UNITE) && (pos2_q < pos1_q)) ?
                    UW'(pos2_q) : UW'(pos1_q);

  always_comb begin
    dec_status  = cra_pkg::STAT_OK;
    dec_compact = 1'b0;
    dec_append  = 1'b0;
    case (func_q)
      cra_pkg::FUNC_ADD: begin
        if (req_q == '0) begin
          dec_status = cra_pkg::STAT_BAD_SIZE;
        end else if ((req_w > room_w) || (count_q >= UW'(CAPACITY_UNITS))) begin
          dec_status = cra_pkg::STAT_NO_ROOM;
        end else begin
          dec_append = 1'b1;
        end
      end
      cra_pkg::FUNC_DELETE: begin
        if (!hit1_q) dec_status = cra_pkg::STAT_NOT_FOUND;
        else dec_compact = 1'b1;
      end
      cra_pkg::FUNC_UNITE: begin
        if ((id1_q == id2_q) || !hit1_q || !hit2_q) begin
          dec_status = cra_pkg::STAT_NOT_FOUND;
        end else begin
          dec_compact = 1'b1;
          dec_append  = 1'b1;
        end
      end
      cra_pkg::FUNC_QUERY: begin
        if (!hit1_q) dec_status = cra_pkg::STAT_NOT_FOUND;
      end
      default: begin
        dec_status = cra_pkg::STAT_NOT_FOUND;
      end
    endcase
  end

  assign stat_o.sweep_done = (rd_ptr_q == count_q) && !rd_vld_q;
  assign stat_o.ok         = (dec_status == cra_pkg::STAT_OK);
  assign stat_o.compact    = dec_compact;
  assign stat_o.append     = dec_append;
  assign stat_o.out_busy   = out_vld_q && !out_ready_i;

  // allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      fresh_q <= '0;
    end else begin
      if (cmd_i.decide && (dec_status == cra_pkg::STAT_OK)) begin
        case (func_q)
          cra_pkg::FUNC_ADD:    total_q <= total_q + UW'(req_q);
          cra_pkg::FUNC_DELETE: total_q <= total_q - size1_q;
          default:              total_q <= total_q;
        endcase
      end
      if (cmd_i.sweep_end) begin
        count_q <= wr_ptr_q;
      end
      if (cmd_i.append) begin
        count_q <= wr_ptr_q + UW'(1);
        fresh_q <= fresh_q + IDW'(1);
      end
    end
  end

  // read pipeline valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
    end
  end

  // item capture, pointers, scan findings
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q   <= cra_pkg::func_e'(func_i);
      req_q    <= req_size_i;
      id1_q    <= first_id_i;
      id2_q    <= second_id_i;
      rd_ptr_q <= '0;
      acc_q    <= '0;
      hit1_q   <= 1'b0;
      hit2_q   <= 1'b0;
    end else begin
      if (rd_issue) begin
        rd_ptr_q <= rd_ptr_q + UW'(1);
        rd_idx_q <= rd_ptr_q[IW-1:0];
      end
      // scan: first match of each id, and the offset of the first id
      if (cmd_i.scan && rd_vld_q) begin
        acc_q <= acc_q + rdata_size;
        if (!hit1_q && (rdata_id == id1_q)) begin
          hit1_q  <= 1'b1;
          pos1_q  <= rd_idx_q;
          off1_q  <= acc_q;
          size1_q <= rdata_size;
        end
        if (!hit2_q && (rdata_id == id2_q)) begin
          hit2_q  <= 1'b1;
          pos2_q  <= rd_idx_q;
          size2_q <= rdata_size;
        end
      end
      // sweep: surviving entries move down
      if (cmd_i.sweep && rd_vld_q && keep) begin
        wr_ptr_q <= wr_ptr_q + UW'(1);
      end
      // decision: set up the sweep and the append
      if (cmd_i.decide) begin
        rd_ptr_q   <= lo_pos;
        wr_ptr_q   <= (func_q == cra_pkg::FUNC_ADD) ? count_q : lo_pos;
        app_size_q <= (func_q == cra_pkg::FUNC_ADD) ? UW'(req_q) : combined;
      end
    end
  end

  // pending result fields from the decision
  always_comb begin
    res_status_d = dec_status;
    res_id_d     = '0;
    res_off_d    = '0;
    res_size_d   = '0;
    res_used_d   = total_q;
    if (dec_status == cra_pkg::STAT_OK) begin
      case (func_q)
        cra_pkg::FUNC_ADD: begin
          res_id_d   = fresh_q;
          res_off_d  = total_q;
          res_size_d = UW'(req_q);
          res_used_d = total_q + UW'(req_q);
        end
        cra_pkg::FUNC_DELETE: begin
          res_id_d   = id1_q;
          res_off_d  = off1_q;
          res_size_d = size1_q;
          res_used_d = total_q - size1_q;
        end
        cra_pkg::FUNC_UNITE: begin
          res_id_d   = fresh_q;
          res_off_d  = total_q - combined;
          res_size_d = combined;
        end
        cra_pkg::FUNC_QUERY: begin
          res_id_d   = id1_q;
          res_off_d  = off1_q;
          res_size_d = size1_q;
        end
        default: begin
          res_id_d = '0;
        end
      endcase
    end
  end

  // pending result, settled at the decision
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_off_q    <= res_off_d;
      res_size_q   <= res_size_d;
      res_used_q   <= res_used_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_off_q    <= cra_pkg::OFF_W'(res_off_q);
      out_size_q   <= cra_pkg::SIZE_W'(res_size_q);
      out_used_q   <= cra_pkg::USED_W'(res_used_q);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_status_q;
  assign region_id_o     = out_id_q;
  assign region_offset_o = out_off_q;
  assign region_size_o   = out_size_q;
  assign used_units_o    = out_used_q;

endmodule

[src/compacting_region_allocator_top.sv]
// Top level of the compacting region allocator: controller, datapath, channels.
// Depends on cra_pkg, cra_req_if, cra_rsp_if, cra_ctrl and cra_datapath.
//
// Usage:
//   req_i carries one command item (add, delete, unite, query); rsp_o returns
//   exactly one result item per command, in order.
//   Commands are handled one at a time. A command scans the region list
//   through the RAM read port, one entry per cycle, then passes a decision
//   state. Delete and unite add a compaction sweep from the lowest removed
//   position to the end of the list (one entry per cycle on the same read
//   port), add and unite add an append state, and the done state loads the
//   result register once the earlier result is taken; the next item is
//   accepted after that load. The result register decouples the sides: a
//   stalled receiver holds the result, the next command is still accepted
//   and worked on, and its result waits until the earlier one is taken.
//   Reset empties the region list and restarts fresh ids at zero; no
//   clearing pass is needed, since only live entries are ever read.

module compacting_region_allocator_top #(
  parameter int unsigned CAPACITY_UNITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cra_req_if.sink           req_i,
  cra_rsp_if.source         rsp_o
);

  cra_pkg::cmd_t  cmd;
  cra_pkg::stat_t stat;

  // sequencing
  cra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // list storage and arithmetic
  cra_datapath #(.CAPACITY_UNITS(CAPACITY_UNITS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .func_i          (req_i.func),
    .req_size_i      (req_i.req_size),
    .first_id_i      (req_i.first_id),
    .second_id_i     (req_i.second_id),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .status_o        (rsp_o.status),
    .region_id_o     (rsp_o.region_id),
    .region_offset_o (rsp_o.region_offset),
    .region_size_o   (rsp_o.region_size),
    .used_units_o    (rsp_o.used_units)
  );

`ifndef SYNTHESIS
  // a loaded result is presented on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> rsp_o.valid)
    else $error("result load did not raise rsp valid");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !stat.out_busy)
    else $error("result register overwritten while stalled");

  // after an accepted item the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second item accepted while one is in work");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking testbench of compacting_region_allocator_top: random and directed commands
// checked against a region-list tracker. Depends on cra_pkg, cra_req_if, cra_rsp_if and the
// block's RTL.

module tb_top;

  localparam int unsigned CAPACITY = 16;

  typedef struct packed {
    cra_pkg::status_e                status;
    logic [cra_pkg::ID_W-1:0]        region_id;
    logic [cra_pkg::OFF_W-1:0]       region_offset;
    logic [cra_pkg::SIZE_W-1:0]      region_size;
    logic [cra_pkg::USED_W-1:0]      used_units;
  } alloc_result_t;

  // tracks the live regions and the results they should produce
  class region_scoreboard;
    logic [cra_pkg::ID_W-1:0]   live_id   [CAPACITY];
    logic [cra_pkg::SIZE_W-1:0] live_size [CAPACITY];
    int unsigned                n_regions;
    int unsigned                units_used;
    logic [cra_pkg::ID_W-1:0]   fresh_id;
    alloc_result_t              pending_results[$];
    int unsigned                errors;
    int unsigned                results_seen;

    function new();
      n_regions    = 0;
      units_used   = 0;
      fresh_id     = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // earliest region in allocation order with this id
    function int position_of(logic [cra_pkg::ID_W-1:0] id);
      for (int i = 0; i < n_regions; i++) begin
        if (live_id[i] == id) return i;
      end
      return -1;
    endfunction

    // remove one region; later ones shift down
    function void drop_at(int pos);
      units_used -= live_size[pos];
      for (int i = pos; i + 1 < n_regions; i++) begin
        live_id[i]   = live_id[i+1];
        live_size[i] = live_size[i+1];
      end
      n_regions--;
    endfunction

    // append a region with the next fresh id
    function alloc_result_t push_region(int unsigned units);
      alloc_result_t r;
      r.status              = cra_pkg::STAT_OK;
      r.region_id           = fresh_id;
      r.region_offset       = units_used[cra_pkg::OFF_W-1:0];
      r.region_size         = units[cra_pkg::SIZE_W-1:0];
      live_id[n_regions]    = fresh_id;
      live_size[n_regions]  = units[cra_pkg::SIZE_W-1:0];
      n_regions++;
      units_used += units;
      fresh_id   = fresh_id + 1'b1;
      r.used_units          = units_used[cra_pkg::USED_W-1:0];
      return r;
    endfunction

    // work out the result of one accepted command
    function void note_command(cra_pkg::func_e op, logic [cra_pkg::REQ_W-1:0] req,
                               logic [cra_pkg::ID_W-1:0] a, logic [cra_pkg::ID_W-1:0] b);
      alloc_result_t r;
      int            pa;
      int            pb;
      int unsigned   off;
      int unsigned   joined;
      r = '0;
      case (op)
        cra_pkg::FUNC_ADD: begin
          if (req == 0) begin
            r.status = cra_pkg::STAT_BAD_SIZE;
          end else if (req > CAPACITY - units_used || n_regions >= CAPACITY) begin
            r.status = cra_pkg::STAT_NO_ROOM;
          end else begin
            r = push_region(req);
          end
        end
        cra_pkg::FUNC_DELETE, cra_pkg::FUNC_QUERY: begin
          pa = position_of(a);
          if (pa < 0) begin
            r.status = cra_pkg::STAT_NOT_FOUND;
          end else begin
            off = 0;
            for (int i = 0; i < pa; i++) off += live_size[i];
            r.region_id     = a;
            r.region_offset = off[cra_pkg::OFF_W-1:0];
            r.region_size   = live_size[pa];
            if (op == cra_pkg::FUNC_DELETE) drop_at(pa);
          end
        end
        default: begin
          pa = position_of(a);
          pb = position_of(b);
          if (a == b || pa < 0 || pb < 0) begin
            r.status = cra_pkg::STAT_NOT_FOUND;
          end else begin
            joined = live_size[pa] + live_size[pb];
            // remove the later one first so the earlier position stays valid
            if (pa > pb) begin
              drop_at(pa);
              drop_at(pb);
            end else begin
              drop_at(pb);
              drop_at(pa);
            end
            r = push_region(joined);
          end
        end
      endcase
      r.used_units = units_used[cra_pkg::USED_W-1:0];
      pending_results = {pending_results, r};
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // compare one result with the oldest pending one
    task check_result(alloc_result_t got);
      alloc_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  results_seen, got.status, want.status));
      if (got.region_id !== want.region_id)
        report_mismatch($sformatf("result %0d region_id %h, expected %h",
                                  results_seen, got.region_id, want.region_id));
      if (got.region_offset !== want.region_offset)
        report_mismatch($sformatf("result %0d region_offset %0d, expected %0d",
                                  results_seen, got.region_offset, want.region_offset));
      if (got.region_size !== want.region_size)
        report_mismatch($sformatf("result %0d region_size %0d, expected %0d",
                                  results_seen, got.region_size, want.region_size));
      if (got.used_units !== want.used_units)
        report_mismatch($sformatf("result %0d used_units %0d, expected %0d",
                                  results_seen, got.used_units, want.used_units));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   gaps_on;
  bit   long_hold;

  region_scoreboard sb;

  cra_req_if req_if ();
  cra_rsp_if rsp_if ();

  compacting_region_allocator_top #(
    .CAPACITY_UNITS (CAPACITY)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("compacting_region_allocator_top test failed");
    $finish;
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
        rsp_if.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : rsp_monitor
    alloc_result_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.status        = cra_pkg::status_e'(rsp_if.status);
      got.region_id     = rsp_if.region_id;
      got.region_offset = rsp_if.region_offset;
      got.region_size   = rsp_if.region_size;
      got.used_units    = rsp_if.used_units;
      sb.check_result(got);
    end
  end

  // offer one command item; returns at the falling edge after acceptance
  task automatic send_item(cra_pkg::func_e op, logic [cra_pkg::REQ_W-1:0] req,
                           logic [cra_pkg::ID_W-1:0] a, logic [cra_pkg::ID_W-1:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= op;
    req_if.req_size  <= req;
    req_if.first_id  <= a;
    req_if.second_id <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_command(op, req, a, b);
    @(negedge clk);
  endtask

  // hold the sender until every pending result has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  // mostly a live id, sometimes any id
  function automatic logic [cra_pkg::ID_W-1:0] pick_id();
    if (sb.n_regions > 0 && $urandom_range(0, 9) < 8)
      return sb.live_id[$urandom_range(0, sb.n_regions - 1)];
    return cra_pkg::ID_W'($urandom_range(0, 16'hffff));
  endfunction

  task automatic random_item();
    int unsigned                 roll;
    logic [cra_pkg::REQ_W-1:0]   units;
    logic [cra_pkg::ID_W-1:0]    a;
    logic [cra_pkg::ID_W-1:0]    b;
    roll  = $urandom_range(0, 99);
    units = (roll < 8) ? cra_pkg::REQ_W'($urandom_range(0, 31)) :
                         cra_pkg::REQ_W'($urandom_range(1, 4));
    a     = pick_id();
    b     = ($urandom_range(0, 19) == 0) ? a : pick_id();
    roll  = $urandom_range(0, 99);
    if (roll < 35)      send_item(cra_pkg::FUNC_ADD, units, a, b);
    else if (roll < 60) send_item(cra_pkg::FUNC_DELETE, units, a, b);
    else if (roll < 75) send_item(cra_pkg::FUNC_UNITE, units, a, b);
    else                send_item(cra_pkg::FUNC_QUERY, units, a, b);
  endtask

  // stimulus
  initial begin
    sb               = new();
    gaps_on          = 1'b1;
    long_hold        = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = cra_pkg::FUNC_ADD;
    req_if.req_size  = '0;
    req_if.first_id  = '0;
    req_if.second_id = '0;
    rst_n            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: size limits, unknown and equal ids, full list, compaction
    send_item(cra_pkg::FUNC_ADD, 5'd0, '0, '0);
    send_item(cra_pkg::FUNC_ADD, 5'd31, '0, '0);
    send_item(cra_pkg::FUNC_ADD, 5'd17, '0, '0);
    send_item(cra_pkg::FUNC_QUERY, '0, 16'h5a5a, '0);
    send_item(cra_pkg::FUNC_ADD, 5'd16, '0, '0);
    send_item(cra_pkg::FUNC_ADD, 5'd1, '0, '0);
    send_item(cra_pkg::FUNC_UNITE, '0, 16'd0, 16'd0);
    send_item(cra_pkg::FUNC_UNITE, '0, 16'd0, 16'hffff);
    send_item(cra_pkg::FUNC_DELETE, '0, 16'd0, '0);
    repeat (16) send_item(cra_pkg::FUNC_ADD, 5'd1, '0, '0);
    send_item(cra_pkg::FUNC_ADD, 5'd1, '0, '0);
    send_item(cra_pkg::FUNC_UNITE, '0, 16'd3, 16'd9);
    send_item(cra_pkg::FUNC_QUERY, '0, 16'd12, '0);
    send_item(cra_pkg::FUNC_DELETE, '0, 16'd1, '0);
    drain();

    // random commands with a long receiver hold-off and a full drain inside
    for (int i = 0; i < 2000; i++) begin
      if (i == 300) long_hold = 1'b1;
      if (i == 900) drain();
      if (i == 1700) gaps_on = 1'b0;
      random_item();
    end

    // wait for the tail, then give the block time to show any extra result
    req_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("compacting_region_allocator_top test passed");
    end else begin
      $display("compacting_region_allocator_top test failed");
    end
    $finish;
  end

endmodule

[files.f]
src/cra_pkg.sv
src/cra_req_if.sv
src/cra_rsp_if.sv
src/cra_ram.sv
src/cra_ctrl.sv
src/cra_datapath.sv
src/compacting_region_allocator_top.sv
verif/tb_top.sv
